// ----- rtl/skt_pkg.sv -----
// shared constants for the sorted key table: field widths, kind and status codes
// and parameter defaults; no dependencies
package skt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int NUM_TABLES_DEF  = 4;
  localparam int KEY_DIGITS_DEF  = 6;

  localparam int KIND_W   = 2;
  localparam int SEL_W    = 2;
  localparam int KEY_W    = 24;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 3'd4;

endpackage

// ----- rtl/sorted_key_table_top.sv -----
// sorted key table top level: command decode, table scan sequencer and key memory
// depends on skt_pkg and skt_canon
//
// An item is taken when start is high and busy is low; its single result appears
// on the out_ ports for exactly one cycle with out_valid high, and the receiver
// cannot stall it. All keys live in one single-port-read, one-write synchronous
// memory, each table in its own row range, and every operation walks its table
// one entry per cycle through that memory. An insert makes one forward pass that
// finds the slot and ripples the tail up behind it, stopping early on a duplicate
// or, in a full table, at the first larger entry; a delete walks from the index
// to the end, moving each later entry down; a read fetches that one entry. An
// empty insert key, a bad index or an unused kind answers in the cycle after
// the transfer. The key memory needs no clearing; counts and control are reset.
module sorted_key_table_top #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_TABLES  = skt_pkg::NUM_TABLES_DEF,
  parameter int KEY_DIGITS  = skt_pkg::KEY_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [skt_pkg::KIND_W-1:0]    in_kind,
  input  logic [skt_pkg::SEL_W-1:0]     in_table_select,
  input  logic [skt_pkg::KEY_W-1:0]     in_key,
  input  logic [skt_pkg::IDX_W-1:0]     in_index,
  output logic                          out_valid,
  output logic [skt_pkg::STATUS_W-1:0]  out_status,
  output logic [skt_pkg::POS_W-1:0]     out_position,
  output logic [skt_pkg::KEY_W-1:0]     out_key_out,
  output logic [skt_pkg::COUNT_W-1:0]   out_count
);

  localparam int KB = 4 * KEY_DIGITS;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MD = 1 << (TW + AW);
  localparam int XW = (CW > skt_pkg::IDX_W) ? CW : skt_pkg::IDX_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                         state_r, state_nxt;
  logic [skt_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [TW-1:0]                tsel_r, tsel_nxt;
  logic [KB-1:0]                key_r, key_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                end_r, end_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                rp_r, rp_nxt;
  logic                         dv_r, dv_nxt;
  logic [CW-1:0]                dp_r, dp_nxt;
  logic                         ins_r, ins_nxt;
  logic [KB-1:0]                carry_r, carry_nxt;
  logic [CW-1:0]                at_r, at_nxt;
  logic [KB-1:0]                gone_r, gone_nxt;

  logic [CW-1:0]                counts_r [NUM_TABLES];
  logic                         cnt_we;
  logic [CW-1:0]                cnt_wdata;

  logic                         out_valid_r, out_valid_nxt;
  logic [skt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [skt_pkg::POS_W-1:0]    out_position_r, out_position_nxt;
  logic [skt_pkg::KEY_W-1:0]    out_key_out_r, out_key_out_nxt;
  logic [skt_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [KB-1:0]                mem_r [MD];
  logic [KB-1:0]                rdata_r;
  logic                         mem_we;
  logic [AW-1:0]                mem_woff;
  logic [KB-1:0]                mem_wdata;

  logic [KB-1:0]                key_canon;
  logic [TW-1:0]                t_sel;
  logic [CW-1:0]                cnt_sel;
  logic                         full;

  skt_canon #(
    .KEY_DIGITS (KEY_DIGITS)
  ) u_canon (
    .key_raw   (in_key),
    .key_canon (key_canon)
  );

  always_comb begin
    if (NUM_TABLES == 1) begin
      t_sel = '0;
    end else if (32'(in_table_select) >= NUM_TABLES) begin
      t_sel = TW'(32'(in_table_select) - NUM_TABLES);
    end else begin
      t_sel = TW'(in_table_select);
    end
  end

  assign cnt_sel = counts_r[t_sel];
  assign full    = (cnt_r == CW'(TABLE_DEPTH));
  assign busy    = (state_r == S_SCAN);

  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    tsel_nxt         = tsel_r;
    key_nxt          = key_r;
    cnt_nxt          = cnt_r;
    end_nxt          = end_r;
    idx_nxt          = idx_r;
    rp_nxt           = rp_r;
    dv_nxt           = 1'b0;
    dp_nxt           = dp_r;
    ins_nxt          = ins_r;
    carry_nxt        = carry_r;
    at_nxt           = at_r;
    gone_nxt         = gone_r;
    cnt_we           = 1'b0;
    cnt_wdata        = cnt_r;
    mem_we           = 1'b0;
    mem_woff         = dp_r[AW-1:0];
    mem_wdata        = key_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;
    out_key_out_nxt  = out_key_out_r;
    out_count_nxt    = out_count_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt         = in_kind;
          tsel_nxt         = t_sel;
          key_nxt          = key_canon;
          cnt_nxt          = cnt_sel;
          idx_nxt          = CW'(in_index);
          rp_nxt           = '0;
          ins_nxt          = 1'b0;
          out_status_nxt   = skt_pkg::ST_BADIDX;
          out_position_nxt = in_index;
          out_key_out_nxt  = '0;
          out_count_nxt    = skt_pkg::COUNT_W'(cnt_sel);
          unique case (in_kind)
            skt_pkg::KIND_INSERT: begin
              if (key_canon == '0) begin
                out_valid_nxt    = 1'b1;
                out_status_nxt   = skt_pkg::ST_EMPTY;
                out_position_nxt = '0;
              end else begin
                end_nxt   = cnt_sel;
                state_nxt = S_SCAN;
              end
            end
            skt_pkg::KIND_DELETE, skt_pkg::KIND_READ: begin
              if (XW'(in_index) >= XW'(cnt_sel)) begin
                out_valid_nxt = 1'b1;
              end else begin
                rp_nxt    = CW'(in_index);
                end_nxt   = (in_kind == skt_pkg::KIND_READ) ? CW'(in_index) + 1'b1 : cnt_sel;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rp_r < end_r) begin
          rp_nxt = rp_r + 1'b1;
          dv_nxt = 1'b1;
          dp_nxt = rp_r;
        end
        out_position_nxt = skt_pkg::POS_W'(idx_r);
        out_count_nxt    = skt_pkg::COUNT_W'(cnt_r);
        if (dv_r) begin
          unique case (kind_r)
            skt_pkg::KIND_INSERT: begin
              if (ins_r) begin
                mem_we    = 1'b1;
                mem_wdata = carry_r;
                carry_nxt = rdata_r;
              end else if (rdata_r == key_r) begin
                out_valid_nxt    = 1'b1;
                out_status_nxt   = skt_pkg::ST_DUP;
                out_position_nxt = skt_pkg::POS_W'(dp_r);
                out_key_out_nxt  = skt_pkg::KEY_W'(rdata_r);
                state_nxt        = S_IDLE;
                dv_nxt           = 1'b0;
              end else if (rdata_r > key_r) begin
                if (full) begin
                  out_valid_nxt    = 1'b1;
                  out_status_nxt   = skt_pkg::ST_FULL;
                  out_position_nxt = '0;
                  out_key_out_nxt  = '0;
                  state_nxt        = S_IDLE;
                  dv_nxt           = 1'b0;
                end else begin
                  mem_we    = 1'b1;
                  mem_wdata = key_r;
                  carry_nxt = rdata_r;
                  ins_nxt   = 1'b1;
                  at_nxt    = dp_r;
                end
              end
            end
            skt_pkg::KIND_DELETE: begin
              if (dp_r == idx_r) begin
                gone_nxt = rdata_r;
              end else begin
                mem_we    = 1'b1;
                mem_woff  = AW'(dp_r - 1'b1);
                mem_wdata = rdata_r;
              end
            end
            skt_pkg::KIND_READ: begin
              gone_nxt = rdata_r;
            end
            default: begin
            end
          endcase
        end else if (rp_r >= end_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = skt_pkg::ST_OK;
          state_nxt      = S_IDLE;
          unique case (kind_r)
            skt_pkg::KIND_INSERT: begin
              if (full) begin
                out_status_nxt   = skt_pkg::ST_FULL;
                out_position_nxt = '0;
                out_key_out_nxt  = '0;
              end else begin
                mem_we           = 1'b1;
                mem_woff         = cnt_r[AW-1:0];
                mem_wdata        = ins_r ? carry_r : key_r;
                cnt_we           = 1'b1;
                cnt_wdata        = cnt_r + 1'b1;
                out_position_nxt = skt_pkg::POS_W'(ins_r ? at_r : cnt_r);
                out_key_out_nxt  = skt_pkg::KEY_W'(key_r);
                out_count_nxt    = skt_pkg::COUNT_W'(cnt_r + 1'b1);
              end
            end
            skt_pkg::KIND_DELETE: begin
              cnt_we          = 1'b1;
              cnt_wdata       = cnt_r - 1'b1;
              out_key_out_nxt = skt_pkg::KEY_W'(gone_r);
              out_count_nxt   = skt_pkg::COUNT_W'(cnt_r - 1'b1);
            end
            default: begin
              out_key_out_nxt = skt_pkg::KEY_W'(gone_r);
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[{tsel_r, mem_woff}] <= mem_wdata;
    end
    rdata_r <= mem_r[{tsel_r, rp_r[AW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cnt_we) begin
        counts_r[tsel_r] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r         <= kind_nxt;
    tsel_r         <= tsel_nxt;
    key_r          <= key_nxt;
    cnt_r          <= cnt_nxt;
    end_r          <= end_nxt;
    idx_r          <= idx_nxt;
    rp_r           <= rp_nxt;
    dp_r           <= dp_nxt;
    ins_r          <= ins_nxt;
    carry_r        <= carry_nxt;
    at_r           <= at_nxt;
    gone_r         <= gone_nxt;
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
    out_key_out_r  <= out_key_out_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_key_out  = out_key_out_r;
  assign out_count    = out_count_r;

endmodule

// ----- rtl/skt_canon.sv -----
// key canonicalizer: clears every nibble after the first terminating zero nibble
// depends on skt_pkg for the key port width
module skt_canon #(
  parameter int KEY_DIGITS = skt_pkg::KEY_DIGITS_DEF
) (
  input  logic [skt_pkg::KEY_W-1:0]  key_raw,
  output logic [4*KEY_DIGITS-1:0]    key_canon
);

  localparam int KB = 4 * KEY_DIGITS;

  logic [KB-1:0] key_ext;

  assign key_ext = KB'(key_raw);

  always_comb begin
    logic alive;
    logic [3:0] nib;
    alive = 1'b1;
    key_canon = '0;
    for (int d = KEY_DIGITS - 1; d >= 0; d--) begin
      nib = key_ext[4*d +: 4];
      alive = alive & (nib != 4'd0);
      key_canon[4*d +: 4] = alive ? nib : 4'd0;
    end
  end

endmodule

// ----- rtl/skt_checker.sv -----
// port-level checks for the sorted key table and the bind that attaches them
// depends on skt_pkg and sorted_key_table_top
module skt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [skt_pkg::STATUS_W-1:0]  out_status,
  input logic [skt_pkg::POS_W-1:0]     out_position,
  input logic [skt_pkg::KEY_W-1:0]     out_key_out,
  input logic [skt_pkg::COUNT_W-1:0]   out_count
);

  // a transfer either starts a scan or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("transfer neither started a scan nor produced a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("scan ended without a result");

  a_rejected_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == skt_pkg::ST_EMPTY || out_status == skt_pkg::ST_FULL)
    |-> out_position == '0 && out_key_out == '0)
    else $error("empty or full result carries nonzero fields");

  a_badidx_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == skt_pkg::ST_BADIDX |-> out_key_out == '0 && !$isunknown(out_count))
    else $error("bad index result carries a key");

endmodule

bind sorted_key_table_top skt_checker u_skt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_position (out_position),
  .out_key_out  (out_key_out),
  .out_count    (out_count)
);
